>>> hw/rtl/sas_pkg.sv
// Shared types and constants for the stable ascending sorter.
// Holds the beat payload structs and the control bundle for the sorting cells.
// Depends on nothing.
`default_nettype none

package sas_pkg;

  localparam int unsigned DataW = 32;

  // One beat on the input channel.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } in_beat_t;

  // One beat on the output channel.
  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_beat_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast value into its sorted position
    logic shift;   // advance every value one cell toward the head
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sas_cell.sv
// One cell of the insertion-sort chain: holds one value and its valid bit.
// Depends on sas_pkg (control bundle, data width).
`default_nettype none

module sas_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire sas_pkg::cell_ctrl_t            ctrl_i,
  input  wire logic signed [sas_pkg::DataW-1:0] new_value_i,
  // neighbor toward the head (smaller values)
  input  wire logic signed [sas_pkg::DataW-1:0] left_value_i,
  input  wire logic                           left_valid_i,
  input  wire logic                           left_gt_i,
  // neighbor toward the tail (larger values)
  input  wire logic signed [sas_pkg::DataW-1:0] right_value_i,
  input  wire logic                           right_valid_i,
  output logic signed [sas_pkg::DataW-1:0]      value_o,
  output logic                                valid_o,
  output logic                                gt_o
);

  logic signed [sas_pkg::DataW-1:0] value_q, value_d;
  logic                             valid_q, valid_d;
  logic                             gt;

  // Strict compare keeps equal values in arrival order.
  assign gt = !valid_q || (value_q > new_value_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.shift) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert && gt) begin
      value_d = left_gt_i ? left_value_i : new_value_i;
      valid_d = valid_q || left_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign gt_o    = gt;

endmodule

`default_nettype wire

>>> hw/rtl/stable_ascending_sorter.sv
// Top level of the stable ascending sorter: a chain of insertion cells plus
// load/drain control and an output register. Depends on sas_pkg and sas_cell.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_beat_i) carries one signed
//   32-bit value per beat; in_beat_i.last marks the final beat of a run.
// - While loading, one beat is taken every cycle. Each beat is inserted into
//   the cell chain in the same cycle, so the chain is always sorted; equal
//   values keep their arrival order.
// - Once DEPTH values are held, further beats of the run are dropped and the
//   run is flagged as overflowed (a dropped marked beat still ends the run).
// - After the marked beat, the block drains: N beats (N = values held) leave
//   on the output channel (out_valid_o / out_stall_i / out_beat_o), smallest
//   first, one per cycle unless the receiver stalls. Each result passes from
//   the chain head through the output register; the last carries last_out,
//   and every one carries the run's overflow flag.
// - in_stall_o is high during the drain, so no beat is taken until the
//   run has drained. The next run may load while the final result
//   still waits in the output register.
// - A stalled output beat holds; the chain holds its values until the
//   output register can take the next one.
// - Reset empties the chain, clears the count and flag, and drops any
//   pending output beat.
`default_nettype none

module stable_ascending_sorter #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sas_pkg::in_beat_t  in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sas_pkg::out_beat_t      out_beat_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] OneCnt   = CntW'(1);

  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            out_valid_q, out_valid_d;
  sas_pkg::out_beat_t out_beat_q, out_beat_d;

  logic in_accept, full, emit;
  sas_pkg::cell_ctrl_t ctrl;

  // Chain wiring; index DEPTH is the empty slot past the tail.
  logic signed [sas_pkg::DataW-1:0] cell_value [DEPTH+1];
  logic                             cell_valid [DEPTH+1];
  logic                             cell_gt    [DEPTH];

  assign in_stall_o = (state_q == StDrain);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign full       = (count_q == DepthCnt);
  assign emit       = (state_q == StDrain) && (!out_valid_q || !out_stall_i);

  assign ctrl.insert = in_accept && !full;
  assign ctrl.shift  = emit;

  assign cell_value[DEPTH] = '0;
  assign cell_valid[DEPTH] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sas_pkg::DataW-1:0] left_value;
    logic                             left_valid;
    logic                             left_gt;
    if (i == 0) begin : g_head
      // Head cell has no left neighbor: a displaced value is the new one.
      assign left_value = '0;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    sas_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_value_i   (in_beat_i.value),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .left_gt_i     (left_gt),
      .right_value_i (cell_value[i+1]),
      .right_valid_i (cell_valid[i+1]),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i]),
      .gt_o          (cell_gt[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    out_beat_d  = out_beat_q;

    // Release the output register once the receiver takes the beat.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StLoad: begin
        if (in_accept) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + OneCnt;
          end
          if (in_beat_i.last) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (emit) begin
          // Hand the head value to the output register and advance the chain.
          out_valid_d             = 1'b1;
          out_beat_d.sorted_value = cell_value[0];
          out_beat_d.last_out     = (count_q == OneCnt);
          out_beat_d.overflow     = ovf_q;
          count_d                 = count_q - OneCnt;
          if (count_q == OneCnt) begin
            state_d = StLoad;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_beat_q <= out_beat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

>>> test/stable_ascending_sorter_tb.sv
// Self-checking testbench for stable_ascending_sorter: runs of signed values go
// in, each run comes back sorted and is compared beat by beat with a predictor.
// Depends on sas_pkg and the stable_ascending_sorter RTL only.
`default_nettype none

module stable_ascending_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [sas_pkg::DataW-1:0] word_t;

  // Store size of the block under test; the predictor drops beyond it as well.
  localparam int unsigned RunCap = 64;
  // Cycles with no beat on either channel before the run is declared hung.
  localparam int unsigned QuietLimit = 4000;
  // Cycles to wait once the last sorted beat is in, to catch stray output.
  localparam int unsigned DrainSlack = 20;
  // Rough number of random input beats per phase.
  localparam int unsigned PhaseItems = 32;
  localparam int unsigned ReportCap = 10;
  localparam int unsigned NumPhases = 4;

  localparam word_t MinWord = 32'sh8000_0000;
  localparam word_t MaxWord = 32'sh7FFF_FFFF;
  localparam word_t AllOnes = 32'shFFFF_FFFF;

  // Sender idle and receiver stall percentages for each phase:
  // none, sender only, receiver only, both.
  localparam int unsigned GapPct   [NumPhases] = '{0, 48, 0, 37};
  localparam int unsigned StallPct [NumPhases] = '{0, 0, 48, 37};

  // One row of the directed table. Where pin is set, want is the one result
  // the row must produce, typed in by hand; such rows are single-beat runs
  // that start from an empty store.
  typedef struct packed {
    sas_pkg::in_beat_t  beat;
    logic               pin;
    sas_pkg::out_beat_t want;
  } stim_row_t;

  localparam int unsigned NumRows = 16;
  localparam stim_row_t DirectedRows [NumRows] = '{
    // single-beat runs at the extremes, zero and minus one: each comes straight back, marked last
    '{'{MinWord, 1'b1}, 1'b1, '{MinWord, 1'b1, 1'b0}},
    '{'{MaxWord, 1'b1}, 1'b1, '{MaxWord, 1'b1, 1'b0}},
    '{'{32'sd0,  1'b1}, 1'b1, '{32'sd0,  1'b1, 1'b0}},
    '{'{AllOnes, 1'b1}, 1'b1, '{AllOnes, 1'b1, 1'b0}},
    // mixed signs, both extremes and repeated values in one run
    '{'{32'sd5,   1'b0}, 1'b0, '0},
    '{'{-32'sd3,  1'b0}, 1'b0, '0},
    '{'{MaxWord,  1'b0}, 1'b0, '0},
    '{'{32'sd5,   1'b0}, 1'b0, '0},
    '{'{MinWord,  1'b0}, 1'b0, '0},
    '{'{-32'sd3,  1'b0}, 1'b0, '0},
    '{'{32'sd0,   1'b1}, 1'b0, '0},
    // two beats arriving in descending order
    '{'{32'sd1,   1'b0}, 1'b0, '0},
    '{'{AllOnes,  1'b1}, 1'b0, '0},
    // alternating bit patterns, one of them repeated
    '{'{32'shAAAA_AAAA, 1'b0}, 1'b0, '0},
    '{'{32'sh5555_5555, 1'b0}, 1'b0, '0},
    '{'{32'shAAAA_AAAA, 1'b1}, 1'b0, '0}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  sas_pkg::in_beat_t  in_beat_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sas_pkg::out_beat_t out_beat_o;

  // Predictor state: values of the run being collected and its drop flag.
  word_t              run_words [$];
  logic               run_dropped = 1'b0;
  // Sorted beats still owed by the block, oldest first.
  sas_pkg::out_beat_t sorted_due [$];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;

  stable_ascending_sorter #(
    .DEPTH(RunCap)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always #1 clk_i = ~clk_i;

  // Collect one accepted beat. Keep at most RunCap values and flag the run
  // once one is dropped; a dropped marked beat still closes the run. On the
  // marked beat, sort the run stably (strict compare, so equal values never
  // pass each other) and queue one expected beat per stored value.
  function automatic void absorb_beat(sas_pkg::in_beat_t b);
    word_t              ordered [$];
    word_t              w;
    int                 i;
    int                 j;
    sas_pkg::out_beat_t exp_beat;
    if (run_words.size() < RunCap) begin
      run_words.push_back(b.value);
    end else begin
      run_dropped = 1'b1;
    end
    if (!b.last) begin
      return;
    end
    ordered = run_words;
    for (i = 1; i < ordered.size(); i++) begin
      w = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1] > w) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = w;
    end
    foreach (ordered[k]) begin
      exp_beat.sorted_value = ordered[k];
      exp_beat.last_out     = (k == ordered.size() - 1);
      exp_beat.overflow     = run_dropped;
      sorted_due.push_back(exp_beat);
    end
    run_words.delete();
    run_dropped = 1'b0;
  endfunction

  // Compare one accepted output beat with the oldest expectation.
  function automatic void check_sorted_beat(sas_pkg::out_beat_t got);
    sas_pkg::out_beat_t want;
    if (sorted_due.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportCap) begin
        $display("%0t: output beat with nothing due: value %0d last %0b overflow %0b",
                 $realtime, got.sorted_value, got.last_out, got.overflow);
      end
      return;
    end
    want = sorted_due.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportCap) begin
        $display("%0t: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
                 $realtime, want.sorted_value, want.last_out, want.overflow,
                 got.sorted_value, got.last_out, got.overflow);
      end
    end
  endfunction

  // Half full-range words; the rest lean toward ties, zero and the extremes.
  function automatic word_t random_word();
    word_t w;
    case ($urandom_range(9))
      5, 6:    w = $signed($urandom_range(8)) - 32'sd4;
      7:       w = MinWord;
      8:       w = MaxWord;
      9:       w = $urandom_range(1) ? AllOnes : 32'sd0;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Drive one beat, holding it until accepted. Entered and left at a falling
  // edge. Idle cycles before the beat drop valid; valid is raised only after
  // the last idle cycle, so it is never lowered and raised in one step.
  // Stall is sampled right at the rising edge, before the block updates it.
  task automatic feed_beat(input sas_pkg::in_beat_t b, input logic pin,
                           input sas_pkg::out_beat_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    // Record the expectation at the accepting edge; the first sorted beat
    // can only be taken at a later edge.
    if (pin) begin
      sorted_due.push_back(want);
    end else begin
      absorb_beat(b);
    end
    @(negedge clk_i);
  endtask

  // Send a run of random values, marking the final one.
  task automatic feed_run(input int unsigned len);
    sas_pkg::in_beat_t b;
    int unsigned       n;
    for (n = 0; n < len; n++) begin
      b.value = random_word();
      b.last  = (n == len - 1);
      feed_beat(b, 1'b0, '0);
    end
  endtask

  // Receiver: stall at random, at the rate of the current phase.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Check every output beat the receiver accepts.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_sorted_beat(out_beat_o);
    end
  end

  // Count cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: give up when the block stops moving.
  initial begin
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk_i);
    end
    $display("stable_ascending_sorter test failed");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned phase_sent;
    int unsigned run_len;
    int unsigned r;

    // Hold reset, then release it away from the rising edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (phase = 0; phase < NumPhases; phase++) begin
      gap_pct    = GapPct[phase];
      stall_pct  = StallPct[phase];
      phase_sent = 0;

      // Directed table first, with no idling on either side.
      if (phase == 0) begin
        for (r = 0; r < NumRows; r++) begin
          feed_beat(DirectedRows[r].beat, DirectedRows[r].pin, DirectedRows[r].want);
        end
      end

      // A run that fills the store exactly: no overflow flag.
      if (phase == 1) begin
        feed_run(RunCap);
        phase_sent += RunCap;
      end

      // A run past the store size: the tail, marked beat included, is
      // dropped and every sorted beat of the run carries the overflow flag.
      if (phase == 3) begin
        run_len = $urandom_range(RunCap + 4, RunCap + 1);
        feed_run(run_len);
        phase_sent += run_len;
      end

      // Short runs with random content; now and then a longer one.
      while (phase_sent < PhaseItems) begin
        run_len = ($urandom_range(3) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
        feed_run(run_len);
        phase_sent += run_len;
      end
    end

    // All beats are in: drop valid and let the last runs drain.
    in_valid_i <= 1'b0;
    while (sorted_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainSlack) @(posedge clk_i);

    if (mismatches == 0 && sorted_due.size() == 0) begin
      $display("stable_ascending_sorter test passed");
    end else begin
      $display("stable_ascending_sorter test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
